[rtl/core/integer_printf_formatter_defines.svh]
// Assertion macros for the integer printf formatter
`ifndef INTEGER_PRINTF_FORMATTER_DEFINES_SVH
`define INTEGER_PRINTF_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
`define IPF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipf assertion failed");
`define IPF_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ipf forbidden condition seen");
`else
`define IPF_ASSERT(label, clk, rst_n, prop)
`define IPF_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/core/ipf_pkg.sv]
// Shared types, constants and functions of the integer printf formatter
package ipf_pkg;

    localparam int MAX_WIDTH         = 64;
    localparam int VALUE_BITS        = 32;
    localparam int DATA_BITS         = 32;
    localparam int BCD_DIGITS        = 10;
    localparam int WORD_BITS         = 4 * BCD_DIGITS;
    localparam int DD_BITS_PER_CYCLE = 4;
    localparam int DD_CYCLES         = DATA_BITS / DD_BITS_PER_CYCLE;
    localparam int DD_CNT_BITS       = $clog2(DD_CYCLES);
    localparam int FW_BITS           = 7;
    localparam int LEN_BITS          = $clog2(BCD_DIGITS + 1);
    localparam int Q_DEPTH           = 2;
    localparam int Q_PTR_BITS        = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS        = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_PERCENT = 3'd0,
        REQ_CHAR    = 3'd1,
        REQ_SDEC    = 3'd2,
        REQ_UDEC    = 3'd3,
        REQ_HEXL    = 3'd4,
        REQ_HEXU    = 3'd5
    } t_req;

    localparam logic [1:0] SZ_32 = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_8  = 2'd2;

    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_UPPER_BASE = 8'h37;
    localparam logic [7:0] CH_CASE_GAP   = 8'h20;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 is_int;
        logic                 lower;
        logic                 neg;
        logic [FW_BITS-1:0]   fw;
        logic                 left;
        logic                 zpad;
    } t_job;

    function automatic logic [WORD_BITS-1:0] dd_step(input logic [WORD_BITS-1:0] w,
                                                     input logic bit_in);
        logic [WORD_BITS-1:0] r;
        logic [3:0]           nib;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            nib = w[4*d +: 4];
            if (nib >= 4'd5) begin
                nib = nib + 4'd3;
            end
            r[4*d +: 4] = nib;
        end
        return {r[WORD_BITS-2:0], bit_in};
    endfunction

endpackage

[rtl/core/integer_printf_formatter.sv]
// Top level of the integer printf formatter
// A request is taken when start is high and busy is low. Percent, char and hex
// requests go straight to the FS_DONE state and leave the front end once the queue
// has room; decimal requests first pass through FS_CONV, where the double dabble unit
// converts four bits per cycle. A two-job queue sits between front and back end, so
// busy rises only while a decimal conversion runs or when a finished job waits on a
// full queue. The back end emits one character per cycle, max(field width capped at 64,
// sign plus payload length) characters per request, with no gap between requests that
// already wait in the queue; each character is valid on o_strobe for exactly one cycle
// and cannot be held off, and o_last marks the final character of a request.
module integer_printf_formatter import ipf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_req_type,
    input  logic [DATA_BITS-1:0] i_value,
    input  logic [1:0]           i_size_mode,
    input  logic [FW_BITS-1:0]   i_min_width,
    input  logic                 i_left_justify,
    input  logic                 i_zero_pad,
    output logic                 o_strobe,
    output logic [7:0]           o_out_char,
    output logic                 o_last
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job front_job;
    t_job head_job;

    ipf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_size_mode    (i_size_mode),
        .i_min_width    (i_min_width),
        .i_left_justify (i_left_justify),
        .i_zero_pad     (i_zero_pad),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_job          (front_job)
    );

    ipf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    ipf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_head     (head_job),
        .o_pop      (q_pop),
        .o_strobe   (o_strobe),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule

[rtl/core/ipf_front.sv]
// Front end: accepts and classifies requests, runs the double dabble
module ipf_front import ipf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [2:0]           i_req_type,
    input  logic [DATA_BITS-1:0] i_value,
    input  logic [1:0]           i_size_mode,
    input  logic [FW_BITS-1:0]   i_min_width,
    input  logic                 i_left_justify,
    input  logic                 i_zero_pad,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_job                 o_job
);

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_DONE
    } t_fstate;

    t_fstate                r_state;
    t_job                   r_job;
    logic [DATA_BITS-1:0]   r_bin;
    logic [DD_CNT_BITS-1:0] r_cnt;

    logic                   accept;
    logic [5:0]             arg_bits;
    logic [DATA_BITS-1:0]   mask;
    logic [DATA_BITS-1:0]   cut;
    logic [DATA_BITS-1:0]   mag;
    logic                   is_int;
    logic                   is_dec;
    logic                   is_hex;
    logic                   neg;
    t_job                   new_job;
    logic [WORD_BITS-1:0]   n_word;
    logic [DATA_BITS-1:0]   n_bin;

    assign o_busy = (r_state == FS_CONV) || ((r_state == FS_DONE) && i_q_full);
    assign o_push = (r_state == FS_DONE) && !i_q_full;
    assign o_job  = r_job;
    assign accept = i_start && !o_busy;

    always_comb begin
        case (i_size_mode)
            SZ_16:   arg_bits = 6'd16;
            SZ_8:    arg_bits = 6'd8;
            default: arg_bits = 6'd32;
        endcase
        if (arg_bits > 6'(VALUE_BITS)) begin
            arg_bits = 6'(VALUE_BITS);
        end
        mask   = ~({DATA_BITS{1'b1}} << arg_bits);
        cut    = i_value & mask;
        is_int = i_req_type inside {REQ_SDEC, REQ_UDEC, REQ_HEXL, REQ_HEXU};
        is_dec = i_req_type inside {REQ_SDEC, REQ_UDEC};
        is_hex = i_req_type inside {REQ_HEXL, REQ_HEXU};
        neg    = (i_req_type == REQ_SDEC) && i_value[5'(arg_bits - 6'd1)];
        mag    = neg ? (~(cut | ~mask) + DATA_BITS'(1)) : cut;

        new_job.is_int = is_int;
        new_job.lower  = (i_req_type == REQ_HEXL);
        new_job.neg    = neg;
        new_job.fw     = (i_min_width > FW_BITS'(MAX_WIDTH)) ? FW_BITS'(MAX_WIDTH)
                                                             : i_min_width;
        new_job.left   = i_left_justify;
        new_job.zpad   = i_zero_pad;
        if (is_hex) begin
            new_job.word = {{(WORD_BITS-DATA_BITS){1'b0}}, mag};
        end else if (is_dec) begin
            new_job.word = '0;
        end else if (i_req_type == REQ_CHAR) begin
            new_job.word = {i_value[7:0], {(WORD_BITS-8){1'b0}}};
        end else begin
            new_job.word = {CH_PERCENT, {(WORD_BITS-8){1'b0}}};
        end
    end

    always_comb begin
        n_word = r_job.word;
        n_bin  = r_bin;
        for (int k = 0; k < DD_BITS_PER_CYCLE; k++) begin
            n_word = dd_step(n_word, n_bin[DATA_BITS-1]);
            n_bin  = {n_bin[DATA_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_cnt   <= '0;
        end else if (accept) begin
            r_job   <= new_job;
            r_bin   <= mag;
            r_cnt   <= '0;
            r_state <= is_dec ? FS_CONV : FS_DONE;
        end else if (o_push) begin
            r_state <= FS_IDLE;
        end else if (r_state == FS_CONV) begin
            r_job.word <= n_word;
            r_bin      <= n_bin;
            r_cnt      <= r_cnt + DD_CNT_BITS'(1);
            if (r_cnt == DD_CNT_BITS'(DD_CYCLES - 1)) begin
                r_state <= FS_DONE;
            end
        end
    end

endmodule

[rtl/core/ipf_queue.sv]
// Two-entry job queue between front and back end
`include "integer_printf_formatter_defines.svh"
module ipf_queue import ipf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head
);

    t_job                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr;
    logic [Q_PTR_BITS-1:0] r_rd;
    logic [Q_CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_BITS'(1);
                2'b01:   r_count <= r_count - Q_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `IPF_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full)
    `IPF_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_valid)
    `IPF_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + Q_CNT_BITS'(1)))

endmodule

[rtl/core/ipf_back.sv]
// Back end: sequences sign, padding and digits into one character per cycle
module ipf_back import ipf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    logic                 r_sign0;
    logic [FW_BITS-1:0]   r_padl;
    logic                 r_sign1;
    logic [LEN_BITS-1:0]  r_dig;
    logic [FW_BITS-1:0]   r_padr;
    logic [WORD_BITS-1:0] r_word;
    logic                 r_lit;
    logic                 r_lower;
    logic                 r_zchar;

    logic                 n_sign0;
    logic [FW_BITS-1:0]   n_padl;
    logic                 n_sign1;
    logic [LEN_BITS-1:0]  n_dig;
    logic [FW_BITS-1:0]   n_padr;
    logic [WORD_BITS-1:0] n_word;
    logic                 n_last;
    logic [7:0]           n_char;

    logic                 active;
    logic [3:0]           nib;
    logic [7:0]           dig_char;

    logic [LEN_BITS-1:0]  lz;
    logic                 found;
    logic [LEN_BITS-1:0]  len;
    logic [FW_BITS+1:0]   pad_s;
    logic [FW_BITS-1:0]   pad;
    logic                 zmode;

    assign active = r_sign0 || r_sign1 || (r_padl != '0) || (r_dig != '0) || (r_padr != '0);
    assign nib    = r_word[WORD_BITS-1 -: 4];

    always_comb begin
        if (r_lit) begin
            dig_char = r_word[WORD_BITS-1 -: 8];
        end else if (nib > 4'd9) begin
            dig_char = {4'h0, nib} + CH_UPPER_BASE + (r_lower ? CH_CASE_GAP : 8'h00);
        end else begin
            dig_char = {4'h0, nib} + CH_ZERO;
        end
    end

    always_comb begin
        n_sign0 = r_sign0;
        n_padl  = r_padl;
        n_sign1 = r_sign1;
        n_dig   = r_dig;
        n_padr  = r_padr;
        n_word  = r_word;
        n_char  = CH_SPACE;
        if (r_sign0) begin
            n_char  = CH_MINUS;
            n_sign0 = 1'b0;
        end else if (r_padl != '0) begin
            n_char = r_zchar ? CH_ZERO : CH_SPACE;
            n_padl = r_padl - FW_BITS'(1);
        end else if (r_sign1) begin
            n_char  = CH_MINUS;
            n_sign1 = 1'b0;
        end else if (r_dig != '0) begin
            n_char = dig_char;
            n_dig  = r_dig - LEN_BITS'(1);
            n_word = {r_word[WORD_BITS-5:0], 4'h0};
        end else if (r_padr != '0) begin
            n_padr = r_padr - FW_BITS'(1);
        end
        n_last = active && !n_sign0 && !n_sign1 && (n_padl == '0) && (n_dig == '0)
                 && (n_padr == '0);
    end

    always_comb begin
        lz    = '0;
        found = 1'b0;
        for (int d = BCD_DIGITS - 1; d > 0; d--) begin
            if (!found && (i_head.word[4*d +: 4] == 4'h0)) begin
                lz = lz + LEN_BITS'(1);
            end else begin
                found = 1'b1;
            end
        end
        len   = i_head.is_int ? (LEN_BITS'(BCD_DIGITS) - lz) : LEN_BITS'(1);
        pad_s = {2'b00, i_head.fw} - {{(FW_BITS+2-LEN_BITS){1'b0}}, len}
                - {{(FW_BITS+1){1'b0}}, i_head.neg};
        pad   = pad_s[FW_BITS+1] ? '0 : pad_s[FW_BITS-1:0];
        zmode = i_head.zpad && i_head.is_int && !i_head.left;
    end

    assign o_pop = i_valid && (!active || n_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign0  <= 1'b0;
            r_padl   <= '0;
            r_sign1  <= 1'b0;
            r_dig    <= '0;
            r_padr   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= active;
            if (active) begin
                o_out_char <= n_char;
                o_last     <= n_last;
            end
            if (o_pop) begin
                r_sign0 <= zmode && i_head.neg;
                r_padl  <= i_head.left ? '0 : pad;
                r_sign1 <= !zmode && i_head.neg;
                r_dig   <= len;
                r_padr  <= i_head.left ? pad : '0;
                r_word  <= i_head.is_int ? (i_head.word << {lz, 2'b00}) : i_head.word;
                r_lit   <= !i_head.is_int;
                r_lower <= i_head.lower;
                r_zchar <= zmode;
            end else if (active) begin
                r_sign0 <= n_sign0;
                r_padl  <= n_padl;
                r_sign1 <= n_sign1;
                r_dig   <= n_dig;
                r_padr  <= n_padr;
                r_word  <= n_word;
            end
        end
    end

endmodule

[test/printf_char_checker.sv]
// Checker that predicts and compares the character stream of the integer printf formatter
`timescale 1ns / 100ps

module printf_char_checker import ipf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [2:0]           i_req_type,
    input  logic [DATA_BITS-1:0] i_value,
    input  logic [1:0]           i_size_mode,
    input  logic [FW_BITS-1:0]   i_min_width,
    input  logic                 i_left_justify,
    input  logic                 i_zero_pad,
    input  logic                 i_strobe,
    input  logic [7:0]           i_out_char,
    input  logic                 i_last,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    t_char_exp field_chars_q [$];
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void predict_field(input logic [2:0]         rtype,
                                          input logic [31:0]        raw,
                                          input logic [1:0]         size,
                                          input logic [FW_BITS-1:0] fw_in,
                                          input logic               left,
                                          input logic               zpad);
        logic [7:0]  payload [12];
        logic [31:0] mask;
        logic [31:0] mag;
        logic [39:0] word;
        logic [3:0]  nib;
        logic [7:0]  pad_ch;
        int          bits;
        int          len;
        int          ndig;
        int          pad;
        int          fw;
        bit          neg;
        bit          is_int;
        bit          lower;
        bit          seen;
        neg    = 1'b0;
        is_int = 1'b0;
        lower  = 1'b0;
        seen   = 1'b0;
        len    = 1;
        fw     = (fw_in > MAX_WIDTH) ? MAX_WIDTH : int'(fw_in);
        case (rtype)
            REQ_CHAR: begin
                payload[0] = raw[7:0];
            end
            REQ_SDEC, REQ_UDEC, REQ_HEXL, REQ_HEXU: begin
                bits = (size == SZ_16) ? 16 : (size == SZ_8) ? 8 : 32;
                if (bits > VALUE_BITS) begin
                    bits = VALUE_BITS;
                end
                mask   = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
                mag    = raw & mask;
                is_int = 1'b1;
                if (rtype == REQ_SDEC && mag[bits-1]) begin
                    neg = 1'b1;
                    mag = ~(mag | ~mask) + 32'd1;
                end
                if (rtype == REQ_HEXL || rtype == REQ_HEXU) begin
                    word  = {8'h00, mag};
                    ndig  = 8;
                    lower = (rtype == REQ_HEXL);
                end else begin
                    word = '0;
                    for (int i = 31; i >= 0; i--) begin
                        for (int d = 0; d < 10; d++) begin
                            if (word[4*d +: 4] >= 4'd5) begin
                                word[4*d +: 4] = word[4*d +: 4] + 4'd3;
                            end
                        end
                        word = {word[38:0], mag[i]};
                    end
                    ndig = 10;
                end
                len = 0;
                for (int i = ndig - 1; i >= 0; i--) begin
                    nib = word[4*i +: 4];
                    if (seen || nib != 4'd0) begin
                        seen = 1'b1;
                        if (nib > 4'd9) begin
                            payload[len] = CH_UPPER_BASE + nib + (lower ? CH_CASE_GAP : 8'h00);
                        end else begin
                            payload[len] = CH_ZERO + nib;
                        end
                        len++;
                    end
                end
                if (len == 0) begin
                    payload[0] = CH_ZERO;
                    len = 1;
                end
            end
            default: begin
                payload[0] = CH_PERCENT;
            end
        endcase

        pad_ch = (zpad && is_int && !left) ? CH_ZERO : CH_SPACE;
        pad    = fw - len - (neg ? 1 : 0);
        if (pad < 0) begin
            pad = 0;
        end

        if (!left && pad_ch == CH_ZERO && neg) begin
            field_chars_q.push_back('{CH_MINUS, 1'b0});
            neg = 1'b0;
        end
        if (!left) begin
            repeat (pad) field_chars_q.push_back('{pad_ch, 1'b0});
        end
        if (neg) begin
            field_chars_q.push_back('{CH_MINUS, 1'b0});
        end
        for (int i = 0; i < len; i++) begin
            field_chars_q.push_back('{payload[i], 1'b0});
        end
        if (left) begin
            repeat (pad) field_chars_q.push_back('{CH_SPACE, 1'b0});
        end
        field_chars_q[field_chars_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_char_exp want;
        if (!i_rst_n) begin
            field_chars_q.delete();
        end else begin
            if (i_strobe) begin
                if (field_chars_q.size() == 0) begin
                    flag_mismatch($sformatf("char %02h with nothing outstanding", i_out_char));
                end else begin
                    want = field_chars_q.pop_front();
                    if (i_out_char !== want.ch) begin
                        flag_mismatch($sformatf("out_char %02h, predicted %02h",
                                                i_out_char, want.ch));
                    end
                    if (i_last !== want.last) begin
                        flag_mismatch($sformatf("last %b, predicted %b", i_last, want.last));
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_field(i_req_type, i_value, i_size_mode, i_min_width,
                              i_left_justify, i_zero_pad);
            end
        end
        o_pending <= field_chars_q.size();
    end

endmodule

[test/tb.sv]
// Testbench top for the integer printf formatter: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb import ipf_pkg::*; ();

    localparam int         IDLE_LIMIT   = 1000;
    localparam int         RANDOM_ITEMS = 410;
    localparam logic [2:0] REQ_SPARE_6  = 3'd6;
    localparam logic [2:0] REQ_SPARE_7  = 3'd7;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic [2:0]           req_type       = REQ_PERCENT;
    logic [DATA_BITS-1:0] value          = '0;
    logic [1:0]           size_mode      = SZ_32;
    logic [FW_BITS-1:0]   min_width      = '0;
    logic                 left_justify   = 1'b0;
    logic                 zero_pad       = 1'b0;
    logic                 busy;
    logic                 o_strobe;
    logic [7:0]           o_out_char;
    logic                 o_last;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles    = 0;

    always #2 i_clk = ~i_clk;

    integer_printf_formatter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (req_type),
        .i_value        (value),
        .i_size_mode    (size_mode),
        .i_min_width    (min_width),
        .i_left_justify (left_justify),
        .i_zero_pad     (zero_pad),
        .o_strobe       (o_strobe),
        .o_out_char     (o_out_char),
        .o_last         (o_last)
    );

    printf_char_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req_type     (req_type),
        .i_value        (value),
        .i_size_mode    (size_mode),
        .i_min_width    (min_width),
        .i_left_justify (left_justify),
        .i_zero_pad     (zero_pad),
        .i_strobe       (o_strobe),
        .i_out_char     (o_out_char),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [2:0]         rtype,
                                input logic [31:0]        operand,
                                input logic [1:0]         size,
                                input logic [FW_BITS-1:0] fw,
                                input logic               left,
                                input logic               zpad);
        start        <= 1'b1;
        req_type     <= rtype;
        value        <= operand;
        size_mode    <= size;
        min_width    <= fw;
        left_justify <= left;
        zero_pad     <= zpad;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain_output();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [2:0]         rtype;
        logic [31:0]        operand;
        logic [1:0]         size;
        logic [FW_BITS-1:0] fw;
        int                 n;
        int                 burst;
        int                 gap;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_PERCENT, 32'h0,         SZ_32, 7'd0,   1'b0, 1'b0);
        send_request(REQ_PERCENT, 32'h0,         SZ_32, 7'd5,   1'b0, 1'b1);
        pause_sender($urandom_range(0, 3));
        send_request(REQ_PERCENT, 32'hFFFF_FFFF, SZ_8,  7'd5,   1'b1, 1'b0);
        send_request(REQ_CHAR,    32'h0000_0041, SZ_32, 7'd0,   1'b0, 1'b0);
        send_request(REQ_CHAR,    32'hFFFF_FF00, SZ_32, 7'd0,   1'b0, 1'b0);
        send_request(REQ_CHAR,    32'h0000_00FF, SZ_16, 7'd3,   1'b0, 1'b1);
        pause_sender($urandom_range(0, 3));
        send_request(REQ_SDEC,    32'h8000_0000, SZ_32, 7'd0,   1'b0, 1'b0);
        send_request(REQ_SDEC,    32'h7FFF_FFFF, SZ_32, 7'd12,  1'b0, 1'b1);
        send_request(REQ_UDEC,    32'hFFFF_FFFF, SZ_32, 7'd0,   1'b0, 1'b0);
        send_request(REQ_UDEC,    32'h0,         SZ_32, 7'd0,   1'b0, 1'b0);
        pause_sender($urandom_range(0, 3));
        send_request(REQ_SDEC,    32'h0000_FFFF, SZ_16, 7'd6,   1'b0, 1'b1);
        send_request(REQ_SDEC,    32'h0000_0080, SZ_8,  7'd6,   1'b0, 1'b0);
        send_request(REQ_SDEC,    32'h1234_5680, SZ_8,  7'd6,   1'b1, 1'b1);
        send_request(REQ_HEXL,    32'hDEAD_BEEF, SZ_32, 7'd0,   1'b0, 1'b0);
        send_request(REQ_HEXU,    32'hDEAD_BEEF, SZ_32, 7'd12,  1'b0, 1'b1);
        pause_sender($urandom_range(0, 3));
        send_request(REQ_HEXL,    32'h0,         SZ_32, 7'd0,   1'b0, 1'b0);
        send_request(REQ_SPARE_6, 32'h5A5A_5A5A, SZ_16, 7'd2,   1'b0, 1'b1);
        send_request(REQ_SPARE_7, 32'hA5A5_A5A5, SZ_8,  7'd3,   1'b1, 1'b0);
        send_request(REQ_UDEC,    32'hFFFF_FFFF, 2'd3,  7'd0,   1'b0, 1'b0);
        send_request(REQ_HEXU,    32'h0000_000A, SZ_32, 7'd127, 1'b0, 1'b1);
        pause_sender($urandom_range(0, 3));
        send_request(REQ_UDEC,    32'h0000_0001, SZ_32, 7'd64,  1'b1, 1'b1);
        send_request(REQ_UDEC,    32'hABCD_1234, SZ_16, 7'd1,   1'b0, 1'b0);
        send_request(REQ_SDEC,    32'h0000_0005, SZ_32, 7'd3,   1'b0, 1'b1);
        send_request(REQ_CHAR,    32'h0000_007E, SZ_32, 7'd63,  1'b1, 1'b0);
        drain_output();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                case ($urandom_range(0, 15))
                    0, 1:    rtype = 3'($urandom_range(0, 7));
                    2, 3:    rtype = REQ_CHAR;
                    default: rtype = 3'($urandom_range(REQ_SDEC, REQ_HEXU));
                endcase
                case ($urandom_range(0, 4))
                    0:       operand = $urandom_range(0, 15);
                    1:       operand = ~32'($urandom_range(0, 15));
                    2:       operand = 32'h8000_0000 ^ $urandom_range(0, 3);
                    default: operand = $urandom;
                endcase
                size = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    fw = FW_BITS'($urandom_range(0, 127));
                end else begin
                    fw = FW_BITS'($urandom_range(0, 12));
                end
                send_request(rtype, operand, size, fw,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                n++;
                if (n == RANDOM_ITEMS / 2) begin
                    drain_output();
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 14));
            pause_sender(gap);
        end

        drain_output();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ipf_pkg.sv
rtl/core/ipf_front.sv
rtl/core/ipf_queue.sv
rtl/core/ipf_back.sv
rtl/core/integer_printf_formatter.sv
test/printf_char_checker.sv
test/tb.sv
